/* rtl/rpn_stack_calculator_defines.svh */
// Assertion macros for the RPN calculator block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef RPN_STACK_CALCULATOR_DEFINES_SVH
`define RPN_STACK_CALCULATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The condition holds at every clock edge out of reset.
`define RPN_CHECK(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("rpn check failed");

// The antecedent at one edge forces the consequent at the next edge.
`define RPN_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpn sequence check failed");

`else

`define RPN_CHECK(lbl, cond)
`define RPN_CHECK_NEXT(lbl, ante, cons)

`endif

`endif

/* rtl/rpn_pkg.sv */
package rpn_pkg;

  localparam int WORD_BITS   = 32;
  localparam int STACK_DEPTH = 128;
  localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
  localparam int CNT_W       = 8;
  localparam int FILL_W      = 8;
  localparam int OP_W        = 3;
  localparam int DIGIT_W     = 4;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [OP_W-1:0] {
    OP_DIGIT = 3'd0,
    OP_ENTER = 3'd1,
    OP_ADD   = 3'd2,
    OP_SUB   = 3'd3,
    OP_AND   = 3'd4,
    OP_OR    = 3'd5,
    OP_XOR   = 3'd6,
    OP_NOT   = 3'd7
  } op_t;

  // Shift commands for the row of stack cells.
  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctrl_t;

endpackage

/* rtl/rpn_cell.sv */
module rpn_cell (
  input  logic              clk,
  input  rpn_pkg::stk_ctrl_t ctrl,
  input  rpn_pkg::word_t    from_above,
  input  rpn_pkg::word_t    from_below,
  output rpn_pkg::word_t    q
);
  import rpn_pkg::*;

  word_t q_r;

  // A push moves values away from the top, a pop moves them toward it.
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      q_r <= from_above;
    end else if (ctrl.pop) begin
      q_r <= from_below;
    end
  end

  assign q = q_r;

endmodule

/* rtl/rpn_stack.sv */
module rpn_stack (
  input  logic               clk,
  input  rpn_pkg::stk_ctrl_t ctrl,
  input  rpn_pkg::word_t     push_data,
  output rpn_pkg::word_t     top_data
);
  import rpn_pkg::*;

  word_t cell_q [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    word_t above;
    word_t below;

    if (i == 0) begin : g_top
      assign above = push_data;
    end else begin : g_mid
      assign above = cell_q[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = '0;
    end else begin : g_up
      assign below = cell_q[i+1];
    end

    rpn_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .from_above (above),
      .from_below (below),
      .q          (cell_q[i])
    );
  end

  assign top_data = cell_q[0];

endmodule

/* rtl/rpn_stack_calculator.sv */
// Channel   Ports                                         Handshake
// input     in_operation, in_digit_value                  start high while busy low
// result    out_x_value, out_y_value, out_display_refresh, out_strobe, one cycle
//           out_push_dropped, out_stack_fill
//
// An item is taken at the edge where start is high and busy is low; its result
// is shown with out_strobe high during the next cycle. busy is high during that
// result cycle, which is set by the single update of the X, Y and stack registers.
// Reset is synchronous and clears X, Y, the stack fill, the value count and the
// strobe, and sets the entry mode to lift; the stack cells hold no reset value.
// The receiver cannot stall: every result is taken in the cycle it is shown.
`include "rpn_stack_calculator_defines.svh"

module rpn_stack_calculator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [rpn_pkg::OP_W-1:0]    in_operation,
  input  logic [rpn_pkg::DIGIT_W-1:0] in_digit_value,
  output logic                        out_strobe,
  output logic [rpn_pkg::WORD_BITS-1:0] out_x_value,
  output logic [rpn_pkg::WORD_BITS-1:0] out_y_value,
  output logic                        out_display_refresh,
  output logic                        out_push_dropped,
  output logic [rpn_pkg::FILL_W-1:0]  out_stack_fill
);
  import rpn_pkg::*;

  // Entry mode decides what the next digit does with X.
  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_FRESH  = 2'd1,
    MODE_LIFT   = 2'd2
  } mode_t;

  localparam logic [CNT_W-1:0] CNT_MAX   = '1;
  localparam logic [PTR_W-1:0] PTR_FULL  = PTR_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

  word_t            x_r, x_nxt;
  word_t            y_r, y_nxt;
  logic [PTR_W-1:0] sp_r, sp_nxt;
  logic [CNT_W-1:0] vc_r, vc_nxt;
  mode_t            mode_r, mode_nxt;
  logic             strobe_r;
  logic             refresh_r, refresh_nxt;
  logic             dropped_r, dropped_nxt;

  logic      accept;
  op_t       op;
  word_t     stack_top;
  stk_ctrl_t stk_ctrl;
  logic      do_lift;
  logic      push_req;
  word_t     x_base;

  assign accept = start && !busy;
  assign op     = op_t'(in_operation);

  // The stack is a row of shift cells with the top entry in cell zero.
  rpn_stack u_stack (
    .clk       (clk),
    .ctrl      (stk_ctrl),
    .push_data (y_r),
    .top_data  (stack_top)
  );

  always_comb begin
    x_nxt       = x_r;
    y_nxt       = y_r;
    sp_nxt      = sp_r;
    vc_nxt      = vc_r;
    mode_nxt    = mode_r;
    refresh_nxt = 1'b1;
    dropped_nxt = 1'b0;
    stk_ctrl    = '0;
    do_lift     = 1'b0;
    push_req    = 1'b0;
    x_base      = x_r;

    if (accept) begin
      unique case (op) inside
        OP_DIGIT: begin
          // A digit after an operation other than ENTER lifts the stack before starting X.
          if (mode_r != MODE_APPEND) begin
            x_base = '0;
            if (mode_r != MODE_FRESH) begin
              do_lift = 1'b1;
            end
          end
          x_nxt    = (x_base << DIGIT_W) | WORD_BITS'(in_digit_value);
          mode_nxt = MODE_APPEND;
        end
        OP_ENTER: begin
          do_lift     = 1'b1;
          mode_nxt    = MODE_FRESH;
          refresh_nxt = 1'b0;
        end
        OP_NOT: begin
          x_nxt    = ~x_r;
          mode_nxt = MODE_LIFT;
        end
        OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR: begin
          case (op)
            OP_ADD:  x_nxt = x_r + y_r;
            OP_SUB:  x_nxt = y_r - x_r;
            OP_AND:  x_nxt = x_r & y_r;
            OP_OR:   x_nxt = x_r | y_r;
            default: x_nxt = x_r ^ y_r;
          endcase
          // Y refills from the stack only when more than one value is counted.
          if ((vc_r > CNT_ONE) && (sp_r != '0)) begin
            stk_ctrl.pop = 1'b1;
            sp_nxt       = sp_r - PTR_W'(1);
            y_nxt        = stack_top;
          end
          if (vc_r != '0) begin
            vc_nxt = vc_r - CNT_ONE;
          end
          mode_nxt = MODE_LIFT;
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase

      // A lift pushes the old Y when more than one value is counted (dropped if full) and copies the old X into Y.
      if (do_lift) begin
        push_req = (vc_r > CNT_ONE);
        if (push_req) begin
          if (sp_r < PTR_FULL) begin
            stk_ctrl.push = 1'b1;
            sp_nxt        = sp_r + PTR_W'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
        end
        if (vc_r != CNT_MAX) begin
          vc_nxt = vc_r + CNT_ONE;
        end
        y_nxt = x_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r      <= '0;
      y_r      <= '0;
      sp_r     <= '0;
      vc_r     <= '0;
      mode_r   <= MODE_LIFT;
      strobe_r <= 1'b0;
    end else begin
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      sp_r     <= sp_nxt;
      vc_r     <= vc_nxt;
      mode_r   <= mode_nxt;
      strobe_r <= accept;
    end
  end

  // The flags travel with the result and need no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      refresh_r <= refresh_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  assign busy                = strobe_r;
  assign out_strobe          = strobe_r;
  assign out_x_value         = x_r;
  assign out_y_value         = y_r;
  assign out_display_refresh = refresh_r;
  assign out_push_dropped    = dropped_r;
  assign out_stack_fill      = FILL_W'(sp_r);

  // Every accepted item shows its result in the following cycle.
  `RPN_CHECK_NEXT(a_result_follows, accept, out_strobe)
  // The stack never holds more values than it has cells.
  `RPN_CHECK(a_fill_bound, sp_r <= PTR_FULL)
  // A push is only lost against a full stack.
  `RPN_CHECK(a_drop_full, !(out_strobe && out_push_dropped) || (sp_r == PTR_FULL))

endmodule
